### rtl/core/ial_pkg.sv
// Shared opcodes, status codes and datapath operation types for the integer ALU.
package ial_pkg;

    // Opcode field of an input item
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    // Status field of a result item
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_BADOP   = 2'd2;

    // Multiplier digit width of the shared unit
    localparam int DIGIT_W = 16;

    // Operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        UOP_ADD = 2'd0,
        UOP_SUB = 2'd1,
        UOP_MAC = 2'd2
    } ial_uop_t;

endpackage

### rtl/core/ial_unit.sv
// Shared arithmetic unit: add, subtract, and multiply-by-digit-accumulate.
module ial_unit
    import ial_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  ial_uop_t                uop,
    input  logic [DATA_WIDTH:0]     opa,
    input  logic [DATA_WIDTH:0]     opb,
    input  logic [DIGIT_W-1:0]      digit,
    output logic [DATA_WIDTH:0]     res,
    output logic                    carry
);

    logic [DATA_WIDTH+DIGIT_W-1:0] prod_full;
    logic [DATA_WIDTH:0]           addend;
    logic                          cin;
    logic [DATA_WIDTH+1:0]         sum;

    always_comb
    begin
        prod_full = opb[DATA_WIDTH-1:0] * digit;
        unique case (uop)
            UOP_ADD:
            begin
                addend = opb;
                cin    = 1'b0;
            end
            UOP_SUB:
            begin
                addend = ~opb;
                cin    = 1'b1;
            end
            UOP_MAC:
            begin
                // wrap the partial product to the data width
                addend = {1'b0, prod_full[DATA_WIDTH-1:0]};
                cin    = 1'b0;
            end
            default:
            begin
                addend = '0;
                cin    = 1'b0;
            end
        endcase
        sum   = {1'b0, opa} + {1'b0, addend} + {{(DATA_WIDTH+1){1'b0}}, cin};
        res   = sum[DATA_WIDTH:0];
        carry = sum[DATA_WIDTH+1];
    end

endmodule

### rtl/core/ial_core.sv
// Sequencer and working registers that drive the shared unit for one item at a time.
module ial_core
    import ial_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [2:0]              in_op,
    input  logic [DATA_WIDTH-1:0]   in_a,
    input  logic [DATA_WIDTH-1:0]   in_b,
    output logic                    idle,
    output logic                    done_valid,
    input  logic                    done_take,
    output logic [DATA_WIDTH-1:0]   value,
    output logic [DATA_WIDTH-1:0]   remainder,
    output logic [1:0]              status
);

    localparam int DIGITS = (DATA_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int MPL_W  = DIGITS * DIGIT_W;
    localparam int CNT_W  = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_WIDTH - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(DIGITS - 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_ARITH = 12'b0000_0000_0010,
        S_MUL   = 12'b0000_0000_0100,
        S_NEGA  = 12'b0000_0000_1000,
        S_NEGB  = 12'b0000_0001_0000,
        S_DIV   = 12'b0000_0010_0000,
        S_NEGQ  = 12'b0000_0100_0000,
        S_NEGR  = 12'b0000_1000_0000,
        S_PBIT  = 12'b0001_0000_0000,
        S_PACC  = 12'b0010_0000_0000,
        S_PSQ   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } ial_state_t;

    ial_state_t              state_reg,  state_next;
    logic [2:0]              op_reg,     op_next;
    logic                    a_neg_reg,  a_neg_next;
    logic                    b_neg_reg,  b_neg_next;
    logic [1:0]              st_reg,     st_next;
    logic [DATA_WIDTH-1:0]   acc_reg,    acc_next;
    logic [DATA_WIDTH-1:0]   sq_reg,     sq_next;
    logic [DATA_WIDTH-1:0]   rem_reg,    rem_next;
    logic [DATA_WIDTH-1:0]   exp_reg,    exp_next;
    logic [DATA_WIDTH-1:0]   mcand_reg,  mcand_next;
    logic [MPL_W-1:0]        mplier_reg, mplier_next;
    logic [CNT_W-1:0]        cnt_reg,    cnt_next;

    ial_uop_t                u_op;
    logic [DATA_WIDTH:0]     u_a;
    logic [DATA_WIDTH:0]     u_b;
    logic [DATA_WIDTH:0]     u_res;
    logic                    u_carry;

    ial_unit #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_unit (
        .uop   (u_op),
        .opa   (u_a),
        .opb   (u_b),
        .digit (mplier_reg[DIGIT_W-1:0]),
        .res   (u_res),
        .carry (u_carry)
    );

    // Steer the shared unit
    always_comb
    begin
        u_op = UOP_ADD;
        u_a  = '0;
        u_b  = '0;
        unique case (state_reg)
            S_ARITH:
            begin
                u_op = (op_reg == OP_SUB) ? UOP_SUB : UOP_ADD;
                u_a  = {1'b0, acc_reg};
                u_b  = {1'b0, sq_reg};
            end
            S_NEGA, S_NEGQ:
            begin
                u_op = UOP_SUB;
                u_b  = {1'b0, acc_reg};
            end
            S_NEGB:
            begin
                u_op = UOP_SUB;
                u_b  = {1'b0, sq_reg};
            end
            S_NEGR:
            begin
                u_op = UOP_SUB;
                u_b  = {1'b0, rem_reg};
            end
            S_DIV:
            begin
                u_op = UOP_SUB;
                u_a  = {rem_reg, acc_reg[DATA_WIDTH-1]};
                u_b  = {1'b0, sq_reg};
            end
            S_MUL, S_PACC:
            begin
                u_op = UOP_MAC;
                u_a  = {1'b0, acc_reg};
                u_b  = {1'b0, mcand_reg};
            end
            S_PSQ:
            begin
                u_op = UOP_MAC;
                u_a  = {1'b0, sq_reg};
                u_b  = {1'b0, mcand_reg};
            end
            default:
            begin
                u_op = UOP_ADD;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        a_neg_next  = a_neg_reg;
        b_neg_next  = b_neg_reg;
        st_next     = st_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        rem_next    = rem_reg;
        exp_next    = exp_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = in_op;
                    a_neg_next = in_a[DATA_WIDTH-1];
                    b_neg_next = in_b[DATA_WIDTH-1];
                    st_next    = ST_OK;
                    acc_next   = in_a;
                    sq_next    = in_b;
                    rem_next   = '0;
                    exp_next   = in_b;
                    cnt_next   = '0;
                    unique case (in_op)
                        OP_ADD, OP_SUB:
                        begin
                            state_next = S_ARITH;
                        end
                        OP_MUL:
                        begin
                            acc_next    = '0;
                            mcand_next  = in_a;
                            mplier_next = MPL_W'(in_b);
                            state_next  = S_MUL;
                        end
                        OP_DIV:
                        begin
                            if (in_b == '0)
                            begin
                                acc_next   = '0;
                                st_next    = ST_DIVZERO;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_NEGA;
                            end
                        end
                        OP_POW:
                        begin
                            acc_next = DATA_WIDTH'(1);
                            sq_next  = in_a;
                            // zero or negative exponent gives one
                            if (in_b == '0 || in_b[DATA_WIDTH-1])
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_PBIT;
                            end
                        end
                        default:
                        begin
                            acc_next   = '0;
                            st_next    = ST_BADOP;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ARITH:
            begin
                acc_next   = u_res[DATA_WIDTH-1:0];
                state_next = S_DONE;
            end
            S_MUL:
            begin
                acc_next    = u_res[DATA_WIDTH-1:0];
                mcand_next  = mcand_reg << DIGIT_W;
                mplier_next = mplier_reg >> DIGIT_W;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_NEGA:
            begin
                if (a_neg_reg)
                begin
                    acc_next = u_res[DATA_WIDTH-1:0];
                end
                state_next = S_NEGB;
            end
            S_NEGB:
            begin
                if (b_neg_reg)
                begin
                    sq_next = u_res[DATA_WIDTH-1:0];
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // restore on borrow, else keep the difference
                rem_next = u_carry ? u_res[DATA_WIDTH-1:0] : u_a[DATA_WIDTH-1:0];
                acc_next = {acc_reg[DATA_WIDTH-2:0], u_carry};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_NEGQ;
                end
            end
            S_NEGQ:
            begin
                if (a_neg_reg != b_neg_reg)
                begin
                    acc_next = u_res[DATA_WIDTH-1:0];
                end
                state_next = S_NEGR;
            end
            S_NEGR:
            begin
                if (a_neg_reg)
                begin
                    rem_next = u_res[DATA_WIDTH-1:0];
                end
                state_next = S_DONE;
            end
            S_PBIT:
            begin
                cnt_next = '0;
                if (exp_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (exp_reg[0])
                begin
                    mcand_next  = acc_reg;
                    mplier_next = MPL_W'(sq_reg);
                    acc_next    = '0;
                    state_next  = S_PACC;
                end
                else
                begin
                    mcand_next  = sq_reg;
                    mplier_next = MPL_W'(sq_reg);
                    sq_next     = '0;
                    state_next  = S_PSQ;
                end
            end
            S_PACC:
            begin
                acc_next    = u_res[DATA_WIDTH-1:0];
                mcand_next  = mcand_reg << DIGIT_W;
                mplier_next = mplier_reg >> DIGIT_W;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next = '0;
                    if (exp_reg[DATA_WIDTH-1:1] == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mcand_next  = sq_reg;
                        mplier_next = MPL_W'(sq_reg);
                        sq_next     = '0;
                        state_next  = S_PSQ;
                    end
                end
            end
            S_PSQ:
            begin
                sq_next     = u_res[DATA_WIDTH-1:0];
                mcand_next  = mcand_reg << DIGIT_W;
                mplier_next = mplier_reg >> DIGIT_W;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    exp_next   = exp_reg >> 1;
                    state_next = S_PBIT;
                end
            end
            S_DONE:
            begin
                if (done_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_neg_reg  <= a_neg_next;
        b_neg_reg  <= b_neg_next;
        st_reg     <= st_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        rem_reg    <= rem_next;
        exp_reg    <= exp_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        cnt_reg    <= cnt_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign done_valid = (state_reg == S_DONE);
    assign value      = acc_reg;
    assign remainder  = rem_reg;
    assign status     = st_reg;

endmodule

### rtl/core/integer_alu_with_power.sv
// Top level of the signed integer ALU with add, subtract, multiply, divide and power.
// Input stream (s_axis_*): one item per operation with opcode, operand_a and operand_b.
// Output stream (m_axis_*): exactly one result item per input item, with value,
// remainder and status, in input order.
// A sequencer works one item at a time around a single shared adder / subtractor /
// DATA_WIDTH x 16 multiply-accumulate unit. Divide is restoring, one quotient bit per
// cycle; power is square-and-multiply. Divide by zero, a bad opcode and an exponent
// of zero or below go straight to the result without using the unit.
// s_axis_tready is high only while the sequencer is idle, from the cycle after the
// result moves into the output register, so a new item is taken only when the
// previous one has left the sequencer.
// The output register holds a finished result while the receiver stalls, so the
// sequencer can take and work a new item; it waits at the end only if the
// previous result has not been taken yet.
// Reset clears the sequencer and the output valid, so no result is made up.
module integer_alu_with_power
    import ial_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    localparam int IN_W  = ((2 * DATA_WIDTH + 3 + 7) / 8) * 8,
    localparam int OUT_W = ((2 * DATA_WIDTH + 2 + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // opcode, operand_a, operand_b
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // value, remainder, status
);

    logic                   core_idle;
    logic                   core_start;
    logic                   core_done;
    logic                   core_take;
    logic [DATA_WIDTH-1:0]  core_value;
    logic [DATA_WIDTH-1:0]  core_rem;
    logic [1:0]             core_status;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]       m_data_reg,  m_data_next;

    // Accept a new item only while the sequencer is idle
    assign s_axis_tready = core_idle;
    assign core_start    = s_axis_tvalid && core_idle;

    ial_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (core_start),
        .in_op      (s_axis_tdata[2:0]),
        .in_a       (s_axis_tdata[DATA_WIDTH+2:3]),
        .in_b       (s_axis_tdata[2*DATA_WIDTH+2:DATA_WIDTH+3]),
        .idle       (core_idle),
        .done_valid (core_done),
        .done_take  (core_take),
        .value      (core_value),
        .remainder  (core_rem),
        .status     (core_status)
    );

    // Move the finished result into the output register when it is empty or draining
    assign core_take = core_done && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (core_take)
        begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_W'({core_status, core_rem, core_value});
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

### rtl/core/ial_checker.sv
// Port-level checker for the integer ALU and its bind to the top level.
module ial_checker
    import ial_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    localparam int IN_W  = ((2 * DATA_WIDTH + 3 + 7) / 8) * 8,
    localparam int OUT_W = ((2 * DATA_WIDTH + 2 + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic [1:0]            chk_status;
    logic [DATA_WIDTH-1:0] chk_value;
    logic [DATA_WIDTH-1:0] chk_rem;
    logic                  chk_in_op_hi;

    assign chk_value    = m_axis_tdata[DATA_WIDTH-1:0];
    assign chk_rem      = m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign chk_status   = m_axis_tdata[2*DATA_WIDTH+1:2*DATA_WIDTH];
    assign chk_in_op_hi = s_axis_tdata[2];

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // Busy for at least the cycle after an item is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while still working");

    // Error results carry zero value and remainder
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && chk_status != ST_OK |-> chk_value == '0 && chk_rem == '0)
        else $error("error result with nonzero payload");

    // Status only takes defined codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> chk_status == ST_OK || chk_status == ST_DIVZERO
                          || chk_status == ST_BADOP)
        else $error("undefined status code");

    // A result for opcode four or above passes the state and output registers
    a_badop_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && chk_in_op_hi && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result appeared too early");

endmodule

bind integer_alu_with_power ial_checker #(.DATA_WIDTH(DATA_WIDTH)) u_ial_checker (.*);
